@@ rtl/akt_pkg.sv @@
// Package for the aging key table: sizes, command and status codes, sequencer
// states and the request, response, table entry and verdict record types.
// No dependencies.
package akt_pkg;

   // Table geometry and field widths
   localparam int ENTRIES      = 16;
   localparam int KEY_BITS     = 32;
   localparam int TIMEOUT_BITS = 16;
   localparam int AGE_BITS     = TIMEOUT_BITS + 1;
   localparam int IDX_BITS     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

   // Command codes
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // Response status codes
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]              command;
      logic [KEY_BITS-1:0]     key;
      logic [TIMEOUT_BITS-1:0] timeout;
   } req_type;

   typedef struct packed {
      logic status;
      logic hit;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [TIMEOUT_BITS-1:0] timeout;
      logic [AGE_BITS-1:0]     age;
   } entry_type;

   // Per-entry verdict from the shared compare unit
   typedef struct packed {
      logic                key_match;
      logic                expire;
      logic [AGE_BITS-1:0] age_next;
   } verdict_type;

endpackage

@@ rtl/akt_entry_mem.sv @@
// Entry store of the aging key table: key, timeout and age per slot.
// One write port, one read port with registered read data. Uses akt_pkg.
module akt_entry_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [akt_pkg::IDX_BITS-1:0] wr_addr,
   input  akt_pkg::entry_type          wr_data,
   input  logic [akt_pkg::IDX_BITS-1:0] rd_addr,
   output akt_pkg::entry_type          rd_data
);

   akt_pkg::entry_type mem_ff [akt_pkg::ENTRIES];
   akt_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/akt_entry_unit.sv @@
// Shared compare unit of the aging key table: key match, age increment and
// expiry test for the one entry under the scan pointer. Uses akt_pkg.
module akt_entry_unit (
   input  logic                             entry_valid,
   input  akt_pkg::entry_type               entry,
   input  logic [akt_pkg::KEY_BITS-1:0]     key,
   output akt_pkg::verdict_type             verdict
);

   logic [akt_pkg::AGE_BITS-1:0] age_inc;

   // Age wraps at its width; it never gets past timeout plus one anyway
   assign age_inc = entry.age + akt_pkg::AGE_BITS'(1);

   always_comb begin
      verdict.key_match = entry_valid && (entry.key == key);
      verdict.age_next  = age_inc;
      verdict.expire    = age_inc > {1'b0, entry.timeout};
   end

endmodule

@@ rtl/aging_key_table_unit.sv @@
// Aging key table, top level: sequencer, valid bits and response register.
// Uses akt_pkg, akt_entry_mem and akt_entry_unit.
//
// A request (insert, lookup or tick) is taken when start is high and busy is
// low. Every request walks all ENTRIES slots one per cycle through a single
// compare unit fed by the entry store's read port; busy stays high from the
// accepting edge until the response is registered, so a new request is not
// taken before the last one is through. Exactly one response per request is
// shown on rsp_data for one cycle with rsp_strobe high; the strobe rises in
// the same cycle that busy falls. It is not held, so the receiver must take it
// in that cycle. A new key takes the lowest free slot; an insert of a new key
// into a full table returns status 1 and changes nothing. Valid bits clear at
// reset; no clearing pass is needed.
module aging_key_table_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  akt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output akt_pkg::rsp_type rsp_data
);

   akt_pkg::state_type state_ff, state_in;
   akt_pkg::req_type   req_ff, req_in;

   logic [akt_pkg::ENTRIES-1:0]  valid_ff, valid_in;
   logic [akt_pkg::IDX_BITS-1:0] issue_idx_ff, issue_idx_in;
   logic                         issue_on_ff, issue_on_in;
   logic [akt_pkg::IDX_BITS-1:0] proc_idx_ff, proc_idx_in;
   logic                         proc_on_ff, proc_on_in;
   logic                         found_ff, found_in;
   logic [akt_pkg::IDX_BITS-1:0] match_idx_ff, match_idx_in;
   logic                         free_found_ff, free_found_in;
   logic [akt_pkg::IDX_BITS-1:0] free_idx_ff, free_idx_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   akt_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         wr_en;
   logic [akt_pkg::IDX_BITS-1:0] wr_addr;
   akt_pkg::entry_type           wr_data;
   akt_pkg::entry_type           rd_data;
   logic                         proc_valid;
   akt_pkg::verdict_type         verdict;

   akt_entry_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   assign proc_valid = valid_ff[proc_idx_ff];

   akt_entry_unit u_unit (
      .entry_valid (proc_valid),
      .entry       (rd_data),
      .key         (req_ff.key),
      .verdict     (verdict)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= akt_pkg::ST_IDLE;
         valid_ff      <= '0;
         issue_on_ff   <= 1'b0;
         proc_on_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         issue_on_ff   <= issue_on_in;
         proc_on_ff    <= proc_on_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_idx_ff <= issue_idx_in;
      proc_idx_ff  <= proc_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Sequencer: accept, walk every slot, then commit and respond
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      issue_idx_in  = issue_idx_ff;
      issue_on_in   = issue_on_ff;
      proc_idx_in   = issue_idx_ff;
      proc_on_in    = 1'b0;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_data       = '{key: rd_data.key, timeout: rd_data.timeout, age: verdict.age_next};

      unique case (state_ff)
         akt_pkg::ST_IDLE: begin
            if (start) begin
               state_in      = akt_pkg::ST_SCAN;
               req_in        = req_data;
               issue_idx_in  = '0;
               issue_on_in   = 1'b1;
               found_in      = 1'b0;
               free_found_in = 1'b0;
            end
         end

         akt_pkg::ST_SCAN: begin
            // Read side: step the pointer through the store
            if (issue_on_ff) begin
               proc_on_in = 1'b1;
               if (issue_idx_ff == akt_pkg::LAST_IDX) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + akt_pkg::IDX_BITS'(1);
               end
            end
            // Evaluate side: one entry per cycle through the shared unit
            if (proc_on_ff) begin
               if (verdict.key_match && !found_ff) begin
                  found_in     = 1'b1;
                  match_idx_in = proc_idx_ff;
               end
               if (!proc_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx_ff;
               end
               if (req_ff.command == akt_pkg::CMD_TICK && proc_valid) begin
                  if (verdict.expire) begin
                     valid_in[proc_idx_ff] = 1'b0;
                  end else begin
                     wr_en = 1'b1;
                  end
               end
               if (proc_idx_ff == akt_pkg::LAST_IDX) begin
                  state_in = akt_pkg::ST_DONE;
               end
            end
         end

         akt_pkg::ST_DONE: begin
            state_in            = akt_pkg::ST_IDLE;
            rsp_strobe_in       = 1'b1;
            rsp_data_in.status  = akt_pkg::STATUS_DONE;
            rsp_data_in.hit     = (req_ff.command == akt_pkg::CMD_LOOKUP) && found_ff;
            wr_data             = '{key: req_ff.key, timeout: req_ff.timeout, age: '0};
            wr_addr             = found_ff ? match_idx_ff : free_idx_ff;
            if (req_ff.command == akt_pkg::CMD_INSERT) begin
               if (found_ff || free_found_ff) begin
                  wr_en             = 1'b1;
                  valid_in[wr_addr] = 1'b1;
               end else begin
                  rsp_data_in.status = akt_pkg::STATUS_FULL;
               end
            end
         end

         default: begin
            state_in = akt_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != akt_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ verif/tb_aging_key_table_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for aging_key_table_unit: directed and random insert,
// lookup and tick requests, checked against an in-bench model of the table.
// Depends on akt_pkg and the aging_key_table_unit RTL.
module tb_aging_key_table_unit;
   import akt_pkg::*;

   // Command value the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1050;
   localparam int ROUND_ITEMS  = 50;
   localparam int KEY_POOL     = 24;
   localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3) + 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   // Table model with the queue of responses still owed by the block
   class aging_table_checker;
      bit                      slot_valid[ENTRIES];
      logic [KEY_BITS-1:0]     slot_key[ENTRIES];
      logic [TIMEOUT_BITS-1:0] slot_timeout[ENTRIES];
      logic [AGE_BITS-1:0]     slot_age[ENTRIES];
      rsp_type                 awaited_rsp[$];
      int                      mismatches;

      function new();
         mismatches = 0;
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      endfunction

      function int find_slot(logic [KEY_BITS-1:0] k);
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && slot_key[i] == k) return i;
         return -1;
      endfunction

      // Update the table for one request and give the response it earns
      function rsp_type apply_request(req_type r);
         rsp_type res;
         int      slot;
         res.status = STATUS_DONE;
         res.hit    = 1'b0;
         case (r.command)
            CMD_INSERT: begin
               slot = find_slot(r.key);
               // new key goes to the lowest free slot
               if (slot < 0)
                  for (int i = ENTRIES - 1; i >= 0; i--)
                     if (!slot_valid[i]) slot = i;
               if (slot < 0) begin
                  res.status = STATUS_FULL;
               end else begin
                  slot_valid[slot]   = 1'b1;
                  slot_key[slot]     = r.key;
                  slot_timeout[slot] = r.timeout;
                  slot_age[slot]     = '0;
               end
            end
            CMD_LOOKUP: begin
               res.hit = (find_slot(r.key) >= 0);
            end
            CMD_TICK: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i]) begin
                     slot_age[i] = slot_age[i] + 1'b1;
                     if (slot_age[i] > slot_timeout[i]) slot_valid[i] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         awaited_rsp.push_back(apply_request(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response: status %0b hit %0b", got.status, got.hit);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.hit !== want.hit) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("response mismatch: status exp %0b got %0b, hit exp %0b got %0b",
                           want.status, got.status, want.hit, got.hit);
            end
         end
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   aging_table_checker  chk;
   int                  cycle_count = 0;
   int                  burst_left;
   logic [KEY_BITS-1:0] key_pool[KEY_POOL];

   aging_key_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) chk.check_response(rsp_data);
         if (start && !busy) chk.note_request(req_data);
      end
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] cmd, logic [KEY_BITS-1:0] k,
                                        logic [TIMEOUT_BITS-1:0] t);
      req_type r;
      r.command = cmd;
      r.key     = k;
      r.timeout = t;
      return r;
   endfunction

   // Mostly keys from a small pool so inserts collide and lookups hit
   function automatic logic [KEY_BITS-1:0] pick_key();
      if ($urandom_range(0, 99) < 90) return key_pool[$urandom_range(0, KEY_POOL - 1)];
      return $urandom;
   endfunction

   // Mostly short lifetimes so ticks expire entries; a few full-range ones
   function automatic logic [TIMEOUT_BITS-1:0] pick_timeout();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return TIMEOUT_BITS'($urandom_range(0, 3));
      if (p < 92) return TIMEOUT_BITS'($urandom_range(4, 40));
      return TIMEOUT_BITS'($urandom_range(0, 65535));
   endfunction

   // Mode 0 fills the table, 1 is balanced, 2 drains it with ticks
   function automatic logic [1:0] pick_command(int mode);
      int p;
      p = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (p < 70) return CMD_INSERT;
            if (p < 90) return CMD_LOOKUP;
            if (p < 98) return CMD_TICK;
         end
         1: begin
            if (p < 40) return CMD_INSERT;
            if (p < 75) return CMD_LOOKUP;
            if (p < 95) return CMD_TICK;
         end
         default: begin
            if (p < 20) return CMD_INSERT;
            if (p < 45) return CMD_LOOKUP;
            if (p < 95) return CMD_TICK;
         end
      endcase
      return CMD_UNUSED;
   endfunction

   // Send one request; bursts of back-to-back requests separated by idle gaps
   task automatic issue(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 30);
         repeat (gap) begin
            @(negedge clock);
            start = 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_answered();
      @(negedge clock);
      start = 1'b0;
      while (chk.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int                  sent;
      int                  round;
      int                  mode;
      logic [1:0]          cmd;
      logic [KEY_BITS-1:0] k;
      chk        = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      burst_left = 0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: key extremes, zero timeout, unused command, overwrite, full table
      issue(make_req(CMD_INSERT, '0, '0));
      issue(make_req(CMD_INSERT, '1, '1));
      issue(make_req(CMD_LOOKUP, '0, '0));
      issue(make_req(CMD_LOOKUP, 32'h0000_0005, '0));
      issue(make_req(CMD_TICK, '0, '0));
      issue(make_req(CMD_LOOKUP, '0, '1));
      issue(make_req(CMD_UNUSED, '1, '1));
      issue(make_req(CMD_INSERT, '1, 16'd1));
      issue(make_req(CMD_LOOKUP, '1, '0));
      for (int i = 1; i < ENTRIES; i++)
         issue(make_req(CMD_INSERT, 32'h0000_1000 + i, 16'd3));
      issue(make_req(CMD_INSERT, 32'hDEAD_BEEF, 16'd7));
      issue(make_req(CMD_INSERT, '1, '0));

      // Random rounds, each with its own command mix
      sent  = 0;
      round = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         repeat (ROUND_ITEMS) begin
            cmd = pick_command(mode);
            k   = (cmd == CMD_INSERT || cmd == CMD_LOOKUP) ? pick_key() : $urandom;
            issue(make_req(cmd, k, (cmd == CMD_INSERT) ? pick_timeout()
                                                       : TIMEOUT_BITS'($urandom)));
            sent++;
         end
         round++;
         if (round == 4 || $urandom_range(0, 2) == 0) wait_all_answered();
      end

      wait_all_answered();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chk.mismatches == 0 && chk.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
